@@ hw/rtl/mer_pkg.sv @@
// Shared types, constants and helper functions for the MIDI event remapper.
// No dependencies; every other file of the block imports this package.
package mer_pkg;

    // Block constants
    localparam int CONTROLLERS = 128;
    localparam int NOTE_LENGTH = 960;
    localparam int TIME_BITS   = 48;
    localparam int MAX_RESULTS = 3;

    // Configuration port geometry
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 8;
    localparam logic [7:0] CTRL_LIMIT = 8'(CONTROLLERS);

    // 7-bit to bend conversion constants
    localparam int TBL_DEPTH   = 128;
    localparam int BEND_SCALE  = 16384;
    localparam int BEND_OFFSET = 1040384;
    localparam int BEND_DIV    = 127;
    localparam int BEND_MIN    = -8192;
    localparam int BEND_MAX    = 8191;
    localparam logic [6:0] LEVEL_MAX = 7'd127;

    // Event kinds
    typedef enum logic [2:0] {
        KIND_NOTE     = 3'd0,
        KIND_CC       = 3'd1,
        KIND_BEND     = 3'd2,
        KIND_PRESSURE = 3'd3,
        KIND_OTHER    = 3'd4
    } kind_t;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_VELOCITY_TARGET   = 3'd0,
        REG_KEY_TARGET        = 3'd1,
        REG_SOURCE_CONTROLLER = 3'd2,
        REG_CONTROLLER_TARGET = 3'd3,
        REG_BEND_TARGET       = 3'd4,
        REG_PRESSURE_TARGET   = 3'd5
    } cfg_reg_t;

    // Destination codes as stored in the registers
    typedef logic signed [7:0] dest_code_t;
    localparam dest_code_t DEST_OFF      = -8'sd1;
    localparam dest_code_t DEST_PRESSURE = -8'sd2;
    localparam dest_code_t DEST_BEND     = -8'sd3;
    localparam dest_code_t DEST_NOTE     = -8'sd4;

    // Decoded destination
    typedef enum logic [2:0] {
        DST_OFF,
        DST_PRESSURE,
        DST_BEND,
        DST_NOTE,
        DST_CC
    } dst_t;

    // Which time pair a result carries
    typedef enum logic [1:0] {
        TS_ORIG,
        TS_MAPPED,
        TS_NOTE
    } tsel_t;

    typedef struct packed {
        dest_code_t  velocity_target;
        dest_code_t  key_target;
        logic [6:0]  source_controller;
        dest_code_t  controller_target;
        dest_code_t  bend_target;
        dest_code_t  pressure_target;
    } cfg_t;

    // One result without its times
    typedef struct packed {
        kind_t              kind;
        logic               orig;
        logic [6:0]         key;
        logic [6:0]         level;
        logic signed [13:0] bend;
        tsel_t              tsel;
    } rec_t;

    // Second-stage values handed to the result builder
    typedef struct packed {
        kind_t              kind;
        logic [6:0]         key;
        logic [6:0]         level;
        logic signed [13:0] bend;
        logic [6:0]         v7_bend;
        logic signed [13:0] bf_level;
        logic signed [13:0] bf_key;
    } arith_t;

    typedef logic [TBL_DEPTH-1:0][13:0] bend_tbl_t;

    // Build the 7-bit to bend table at elaboration
    function automatic bend_tbl_t build_bend_table();
        bend_tbl_t tb;
        int        n;
        tb = '0;
        for (int i = 0; i < TBL_DEPTH; i++)
        begin
            n = (BEND_SCALE * i - BEND_OFFSET) / BEND_DIV;
            if (n < BEND_MIN)
            begin
                n = BEND_MIN;
            end
            if (n > BEND_MAX)
            begin
                n = BEND_MAX;
            end
            tb[i] = 14'(n);
        end
        return tb;
    endfunction

    localparam bend_tbl_t BEND_FROM_7 = build_bend_table();

    // Unused codes act as off
    function automatic dst_t decode_dest(input dest_code_t d);
        dst_t r;
        if (d == DEST_PRESSURE)
        begin
            r = DST_PRESSURE;
        end
        else if (d == DEST_BEND)
        begin
            r = DST_BEND;
        end
        else if (d == DEST_NOTE)
        begin
            r = DST_NOTE;
        end
        else if (!d[7] && ({1'b0, d[6:0]} < CTRL_LIMIT))
        begin
            r = DST_CC;
        end
        else
        begin
            r = DST_OFF;
        end
        return r;
    endfunction

    // Build the mapped event for one destination
    function automatic rec_t map_rec(input dst_t dst, input dest_code_t code,
                                     input logic [6:0] val7,
                                     input logic signed [13:0] bendv);
        rec_t r;
        r      = '0;
        r.tsel = TS_MAPPED;
        case (dst)
            DST_PRESSURE:
            begin
                r.kind  = KIND_PRESSURE;
                r.level = val7;
            end
            DST_BEND:
            begin
                r.kind = KIND_BEND;
                r.bend = bendv;
            end
            DST_NOTE:
            begin
                r.kind  = KIND_NOTE;
                r.key   = val7;
                r.level = LEVEL_MAX;
                r.tsel  = TS_NOTE;
            end
            DST_CC:
            begin
                r.kind  = KIND_CC;
                r.key   = code[6:0];
                r.level = val7;
            end
            default:
            begin
                r.kind = KIND_OTHER;
            end
        endcase
        return r;
    endfunction

endpackage

@@ hw/rtl/mer_evt_if.sv @@
// Request channels of the MIDI event remapper: incoming events and results.
// Depends on mer_pkg for the default time width.
interface mer_in_if
    import mer_pkg::*;
#(
    parameter int TIME_W = TIME_BITS
) ();
    logic               valid;
    logic               ready;
    logic [2:0]         func;
    logic [6:0]         key_or_number;
    logic [6:0]         level;
    logic signed [13:0] bend_in;
    logic [TIME_W-1:0]  start_tick;
    logic [TIME_W-1:0]  end_tick;

    modport source (output valid, func, key_or_number, level, bend_in, start_tick,
                    end_tick, input ready);
    modport sink   (input valid, func, key_or_number, level, bend_in, start_tick,
                    end_tick, output ready);
endinterface

interface mer_out_if
    import mer_pkg::*;
#(
    parameter int TIME_W = TIME_BITS
) ();
    logic               valid;
    logic               ready;
    logic [2:0]         out_kind;
    logic               is_original;
    logic [6:0]         out_key_or_number;
    logic [6:0]         out_level;
    logic signed [13:0] out_bend;
    logic [TIME_W-1:0]  out_start;
    logic [TIME_W-1:0]  out_end;
    logic               last;

    modport source (output valid, out_kind, is_original, out_key_or_number, out_level,
                    out_bend, out_start, out_end, last, input ready);
    modport sink   (input valid, out_kind, is_original, out_key_or_number, out_level,
                    out_bend, out_start, out_end, last, output ready);
endinterface

@@ hw/rtl/mer_cfg.sv @@
// Configuration registers of the MIDI event remapper.
// Depends on mer_pkg for the register indexes and the cfg_t bundle.
module mer_cfg
    import mer_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_write_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    output cfg_t                  cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // Decode the write; a controller number keeps only its low seven bits
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write_en)
        begin
            case (cfg_index)
                REG_VELOCITY_TARGET:   cfg_next.velocity_target   = cfg_wdata;
                REG_KEY_TARGET:        cfg_next.key_target        = cfg_wdata;
                REG_SOURCE_CONTROLLER:
                begin
                    cfg_next.source_controller =
                        ({1'b0, cfg_wdata[6:0]} < CTRL_LIMIT) ? cfg_wdata[6:0] : 7'd0;
                end
                REG_CONTROLLER_TARGET: cfg_next.controller_target = cfg_wdata;
                REG_BEND_TARGET:       cfg_next.bend_target       = cfg_wdata;
                REG_PRESSURE_TARGET:   cfg_next.pressure_target   = cfg_wdata;
                default:               cfg_next = cfg_reg;
            endcase
        end
    end

    // Hold the registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.velocity_target   <= DEST_OFF;
            cfg_reg.key_target        <= DEST_OFF;
            cfg_reg.source_controller <= 7'd0;
            cfg_reg.controller_target <= DEST_OFF;
            cfg_reg.bend_target       <= DEST_OFF;
            cfg_reg.pressure_target   <= DEST_OFF;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

@@ hw/rtl/mer_arith.sv @@
// First two pipeline stages: input capture, then value conversions and times.
// Depends on mer_pkg and the mer_in_if channel.
module mer_arith
    import mer_pkg::*;
#(
    parameter int TIME_W = TIME_BITS
) (
    input  logic              clk,
    input  logic              rst_n,
    mer_in_if.sink            events,
    input  logic              down_ready,
    output logic              s2_valid,
    output arith_t            s2_data,
    output logic [TIME_W-1:0] s2_start,
    output logic [TIME_W-1:0] s2_end,
    output logic [TIME_W-1:0] s2_t,
    output logic [TIME_W-1:0] s2_note_end
);

    localparam logic [TIME_W-1:0] NOTE_LEN_T  = TIME_W'(NOTE_LENGTH);
    localparam logic [TIME_W-1:0] NOTE_LEN_T1 = TIME_W'(NOTE_LENGTH + 1);

    // Stage 1 registers
    logic               s1_valid_reg, s1_valid_next;
    kind_t              s1_kind_reg;
    logic [6:0]         s1_key_reg;
    logic [6:0]         s1_level_reg;
    logic signed [13:0] s1_bend_reg;
    logic [TIME_W-1:0]  s1_start_reg;
    logic [TIME_W-1:0]  s1_end_reg;

    // Stage 2 registers
    logic               s2_valid_reg, s2_valid_next;
    arith_t             s2_data_reg, s2_data_next;
    logic [TIME_W-1:0]  s2_start_reg;
    logic [TIME_W-1:0]  s2_end_reg;
    logic [TIME_W-1:0]  s2_t_reg, s2_t_next;
    logic [TIME_W-1:0]  s2_note_end_reg, s2_note_end_next;

    logic               s1_ready;
    logic               s2_ready;
    logic               s1_load;
    logic               s2_load;
    kind_t              in_kind;
    logic               is_note;
    logic [13:0]        bend_u;
    logic [20:0]        bend_prod;

    // Stall chain: a stage takes new data when empty or draining
    assign s2_ready     = !s2_valid_reg || down_ready;
    assign s1_ready     = !s1_valid_reg || s2_ready;
    assign s1_load      = s1_ready && events.valid;
    assign s2_load      = s2_ready && s1_valid_reg;
    assign events.ready = s1_ready;

    // Fold unknown function codes into other
    assign in_kind = (events.func > 3'(KIND_OTHER)) ? KIND_OTHER : kind_t'(events.func);

    // Bend to 7-bit: (p + 8192) * 127 / 16384, floor
    assign is_note   = (s1_kind_reg == KIND_NOTE);
    assign bend_u    = {~s1_bend_reg[13], s1_bend_reg[12:0]};
    assign bend_prod = {bend_u, 7'd0} - {7'd0, bend_u};

    always_comb
    begin
        s2_data_next.kind     = s1_kind_reg;
        s2_data_next.key      = s1_key_reg;
        s2_data_next.level    = s1_level_reg;
        s2_data_next.bend     = s1_bend_reg;
        s2_data_next.v7_bend  = bend_prod[20:14];
        s2_data_next.bf_level = $signed(BEND_FROM_7[s1_level_reg]);
        s2_data_next.bf_key   = $signed(BEND_FROM_7[s1_key_reg]);
        // Mapped note-on results land one tick after the note
        s2_t_next        = s1_start_reg + TIME_W'(is_note);
        s2_note_end_next = s1_start_reg + (is_note ? NOTE_LEN_T1 : NOTE_LEN_T);
    end

    // Advance valid bits
    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        s2_valid_next = s2_valid_reg;
        if (s1_ready)
        begin
            s1_valid_next = events.valid;
        end
        if (s2_ready)
        begin
            s2_valid_next = s1_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
        end
    end

    // Capture the request
    always_ff @(posedge clk)
    begin
        if (s1_load)
        begin
            s1_kind_reg  <= in_kind;
            s1_key_reg   <= events.key_or_number;
            s1_level_reg <= events.level;
            s1_bend_reg  <= events.bend_in;
            s1_start_reg <= events.start_tick;
            s1_end_reg   <= events.end_tick;
        end
    end

    // Hold converted values
    always_ff @(posedge clk)
    begin
        if (s2_load)
        begin
            s2_data_reg     <= s2_data_next;
            s2_start_reg    <= s1_start_reg;
            s2_end_reg      <= s1_end_reg;
            s2_t_reg        <= s2_t_next;
            s2_note_end_reg <= s2_note_end_next;
        end
    end

    assign s2_valid    = s2_valid_reg;
    assign s2_data     = s2_data_reg;
    assign s2_start    = s2_start_reg;
    assign s2_end      = s2_end_reg;
    assign s2_t        = s2_t_reg;
    assign s2_note_end = s2_note_end_reg;

endmodule

@@ hw/rtl/mer_emit.sv @@
// Last stage: builds up to three results per event and sends them one a cycle while the result channel is ready.
// Depends on mer_pkg and the mer_out_if channel.
module mer_emit
    import mer_pkg::*;
#(
    parameter int TIME_W = TIME_BITS
) (
    input  logic              clk,
    input  logic              rst_n,
    input  cfg_t              cfg,
    input  logic              s2_valid,
    input  arith_t            s2_data,
    input  logic [TIME_W-1:0] s2_start,
    input  logic [TIME_W-1:0] s2_end,
    input  logic [TIME_W-1:0] s2_t,
    input  logic [TIME_W-1:0] s2_note_end,
    output logic              up_ready,
    mer_out_if.source         results
);

    localparam int IDX_W = $clog2(MAX_RESULTS);

    logic              valid_reg, valid_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic [IDX_W-1:0]  cnt_reg;
    rec_t              rec_reg [MAX_RESULTS];
    logic [TIME_W-1:0] start_reg;
    logic [TIME_W-1:0] end_reg;
    logic [TIME_W-1:0] t_reg;
    logic [TIME_W-1:0] note_end_reg;

    rec_t               rec_next [MAX_RESULTS];
    logic [IDX_W-1:0]   cnt_next;
    rec_t               orig;
    rec_t               rec_vel;
    rec_t               rec_key;
    rec_t               rec_main;
    dst_t               dst_vel;
    dst_t               dst_key;
    dst_t               dst_main;
    dest_code_t         code_main;
    logic [6:0]         val_main;
    logic signed [13:0] bend_main;
    logic               vel_on;
    logic               key_on;
    rec_t               cur;
    logic               is_last;
    logic               load;

    // Build the result list for the event in stage 2
    always_comb
    begin
        orig.kind = s2_data.kind;
        orig.orig = 1'b1;
        orig.key  = s2_data.key;
        orig.level = s2_data.level;
        orig.bend = s2_data.bend;
        orig.tsel = TS_ORIG;

        dst_vel = decode_dest(cfg.velocity_target);
        dst_key = decode_dest(cfg.key_target);
        vel_on  = (dst_vel != DST_OFF);
        key_on  = (dst_key != DST_OFF);
        rec_vel = map_rec(dst_vel, cfg.velocity_target, s2_data.level, s2_data.bf_level);
        rec_key = map_rec(dst_key, cfg.key_target, s2_data.key, s2_data.bf_key);

        case (s2_data.kind)
            KIND_CC:
            begin
                dst_main  = (s2_data.key == cfg.source_controller)
                            ? decode_dest(cfg.controller_target) : DST_OFF;
                code_main = cfg.controller_target;
            end
            KIND_BEND:
            begin
                dst_main  = decode_dest(cfg.bend_target);
                code_main = cfg.bend_target;
            end
            KIND_PRESSURE:
            begin
                dst_main  = decode_dest(cfg.pressure_target);
                code_main = cfg.pressure_target;
            end
            default:
            begin
                dst_main  = DST_OFF;
                code_main = DEST_OFF;
            end
        endcase
        val_main  = (s2_data.kind == KIND_BEND) ? s2_data.v7_bend : s2_data.level;
        bend_main = (s2_data.kind == KIND_BEND) ? s2_data.bend : s2_data.bf_level;
        rec_main  = map_rec(dst_main, code_main, val_main, bend_main);

        // Note-on: original first, then velocity, then key, packed together
        rec_next[0] = orig;
        rec_next[1] = vel_on ? rec_vel : rec_key;
        rec_next[2] = rec_key;
        cnt_next    = IDX_W'(1);
        if (s2_data.kind == KIND_NOTE)
        begin
            cnt_next = IDX_W'(1) + IDX_W'(vel_on) + IDX_W'(key_on);
        end
        else if (dst_main != DST_OFF)
        begin
            rec_next[0] = rec_main;
        end
    end

    // Present the current result
    assign cur     = rec_reg[idx_reg];
    assign is_last = (idx_reg == cnt_reg - IDX_W'(1));
    assign load    = !valid_reg || (results.ready && is_last);
    assign up_ready = load;

    // Advance through the list; reload after the last result leaves
    always_comb
    begin
        valid_next = valid_reg;
        idx_next   = idx_reg;
        if (load)
        begin
            valid_next = s2_valid;
            idx_next   = '0;
        end
        else if (results.ready)
        begin
            idx_next = idx_reg + IDX_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            idx_reg   <= '0;
            cnt_reg   <= IDX_W'(1);
        end
        else
        begin
            valid_reg <= valid_next;
            idx_reg   <= idx_next;
            if (load && s2_valid)
            begin
                cnt_reg <= cnt_next;
            end
        end
    end

    // Hold the result list and its times
    always_ff @(posedge clk)
    begin
        if (load && s2_valid)
        begin
            for (int i = 0; i < MAX_RESULTS; i++)
            begin
                rec_reg[i] <= rec_next[i];
            end
            start_reg    <= s2_start;
            end_reg      <= s2_end;
            t_reg        <= s2_t;
            note_end_reg <= s2_note_end;
        end
    end

    // Drive the result channel
    always_comb
    begin
        results.valid             = valid_reg;
        results.out_kind          = cur.kind;
        results.is_original       = cur.orig;
        results.out_key_or_number = cur.key;
        results.out_level         = cur.level;
        results.out_bend          = cur.bend;
        results.last              = is_last;
        case (cur.tsel)
            TS_ORIG:
            begin
                results.out_start = start_reg;
                results.out_end   = end_reg;
            end
            TS_NOTE:
            begin
                results.out_start = t_reg;
                results.out_end   = note_end_reg;
            end
            default:
            begin
                results.out_start = t_reg;
                results.out_end   = '0;
            end
        endcase
    end

endmodule

@@ hw/rtl/midi_event_remapper_unit.sv @@
// Top level of the MIDI event remapper: configuration registers and pipeline.
// Depends on mer_pkg, mer_evt_if, mer_cfg, mer_arith and mer_emit.

// Each accepted event yields one to three result events, sent one per cycle in order
// while the result channel is ready, with last set on the final one. The pipeline has
// three register stages (input capture, value conversion and time adds, result list),
// and the first result of an event is shown once the event reaches the result list.
// A new event can be taken every cycle while each produces a single result and the
// result channel is ready; a note-on with both velocity and key destinations enabled
// occupies the result list register until its three results have left, as it sends one
// result per cycle, and once the stages ahead are full the input side stalls meanwhile.
// Configuration writes are taken at any time but are meant to happen only while the
// block is idle. No clearing pass follows reset.
module midi_event_remapper_unit
    import mer_pkg::*;
#(
    parameter int TIME_W = TIME_BITS
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_write_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    mer_in_if.sink                events,
    mer_out_if.source             results
);

    cfg_t              cfg;
    logic              s2_valid;
    arith_t            s2_data;
    logic [TIME_W-1:0] s2_start;
    logic [TIME_W-1:0] s2_end;
    logic [TIME_W-1:0] s2_t;
    logic [TIME_W-1:0] s2_note_end;
    logic              emit_ready;

    mer_cfg u_cfg (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .cfg          (cfg)
    );

    mer_arith #(
        .TIME_W (TIME_W)
    ) u_arith (
        .clk         (clk),
        .rst_n       (rst_n),
        .events      (events),
        .down_ready  (emit_ready),
        .s2_valid    (s2_valid),
        .s2_data     (s2_data),
        .s2_start    (s2_start),
        .s2_end      (s2_end),
        .s2_t        (s2_t),
        .s2_note_end (s2_note_end)
    );

    mer_emit #(
        .TIME_W (TIME_W)
    ) u_emit (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .s2_valid    (s2_valid),
        .s2_data     (s2_data),
        .s2_start    (s2_start),
        .s2_end      (s2_end),
        .s2_t        (s2_t),
        .s2_note_end (s2_note_end),
        .up_ready    (emit_ready),
        .results     (results)
    );

    // An original result is followed by more only for a note-on
    assert property (@(posedge clk) disable iff (!rst_n)
        results.valid && results.is_original && !results.last
            |-> results.out_kind == 3'(KIND_NOTE))
    else $error("original result not last for a non-note event");

    // A mapped note-on carries full velocity
    assert property (@(posedge clk) disable iff (!rst_n)
        results.valid && !results.is_original && results.out_kind == 3'(KIND_NOTE)
            |-> results.out_level == LEVEL_MAX)
    else $error("mapped note-on without full velocity");

    // A mapped bend leaves key and level clear
    assert property (@(posedge clk) disable iff (!rst_n)
        results.valid && !results.is_original && results.out_kind == 3'(KIND_BEND)
            |-> results.out_key_or_number == 7'd0 && results.out_level == 7'd0)
    else $error("mapped bend with stray key or level");

    // A non-last result that is taken is followed by another of the same event
    assert property (@(posedge clk) disable iff (!rst_n)
        results.valid && results.ready && !results.last |=> results.valid)
    else $error("result list cut short");

endmodule
